// ===== rtl/sha_pkg.sv =====
package sha_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       message_end;
   } req_word_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        digest_last;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD80,
      ST_PADZ,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } core_state_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;

   localparam logic [31:0] IV [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
      32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
      32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
      32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
      32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
      32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
      32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
      32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
      32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_s0(input logic [31:0] x);
      big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] x);
      big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_s0(input logic [31:0] x);
      small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_s1(input logic [31:0] x);
      small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// ===== rtl/sha256_stream_hasher.sv =====
// channel | direction | handshake          | word
// req     | in        | req_push/req_full  | data_byte, byte_present, message_end
// rsp     | out       | rsp_pop/rsp_empty  | digest_word, word_index, digest_last
//
// The core takes bytes only while idle; every 64th byte starts a compression
// (64 rounds of one shared round unit, one chaining add) that holds off input.
// An end word pads one byte per cycle (pausing for any full block) and runs
// one or two more compressions, then holds eight digest words until popped.
// A 4-deep input queue keeps taking words while the core compresses or the
// digest waits. Reset is synchronous; both queues come up empty.
module sha256_stream_hasher #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  sha_pkg::req_word_type req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output sha_pkg::rsp_word_type rsp_data
);
   import sha_pkg::*;

   logic         item_valid, item_pop;
   req_word_type item_data;

   sha_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .push_data  (req_data),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item_data  (item_data)
   );

   sha_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item_data  (item_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== rtl/sha_front.sv =====
module sha_front #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  sha_pkg::req_word_type push_data,
   output logic                  item_valid,
   input  logic                  item_pop,
   output sha_pkg::req_word_type item_data
);
   import sha_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   req_word_type      mem [DEPTH];
   logic [AW-1:0]     wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full       = (cnt_ff == (AW+1)'(DEPTH));
   assign item_valid = (cnt_ff != '0);
   assign do_push    = push && !full;
   assign do_pop     = item_pop && item_valid;
   assign item_data  = mem[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == AW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/sha_core.sv =====
module sha_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   output logic                  item_pop,
   input  sha_pkg::req_word_type item_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output sha_pkg::rsp_word_type rsp_data
);
   import sha_pkg::*;

   core_state_type state_ff, state_in, ret_ff, ret_in;
   logic [5:0]     fill_ff, fill_in;
   logic [60:0]    len_ff, len_in;
   logic [5:0]     rnd_ff, rnd_in;
   logic [2:0]     idx_ff, idx_in;
   logic [31:0]    blk_ff [16];
   logic [31:0]    blk_in [16];
   logic [31:0]    wk_ff [8];
   logic [31:0]    wk_in [8];
   logic [31:0]    cv_ff [8];
   logic [31:0]    cv_in [8];

   logic           start_cmp;
   core_state_type cmp_ret;
   logic           wr_en;
   logic [7:0]     wr_byte;
   logic [63:0]    bits;
   logic [31:0]    t1, t2, w_new;

   assign bits      = {len_ff, 3'b000};
   assign rsp_empty = (state_ff != ST_EMIT);
   assign rsp_data  = '{digest_word: cv_ff[idx_ff], word_index: idx_ff,
                        digest_last: (idx_ff == 3'd7)};

   always_comb begin
      t1 = wk_ff[7] + big_s1(wk_ff[4]) + ((wk_ff[4] & wk_ff[5]) ^ (~wk_ff[4] & wk_ff[6]))
         + ROUND_K[rnd_ff] + blk_ff[0];
      t2 = big_s0(wk_ff[0])
         + ((wk_ff[0] & wk_ff[1]) ^ (wk_ff[0] & wk_ff[2]) ^ (wk_ff[1] & wk_ff[2]));
      w_new = small_s1(blk_ff[14]) + blk_ff[9] + small_s0(blk_ff[1]) + blk_ff[0];
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      fill_in   = fill_ff;
      len_in    = len_ff;
      rnd_in    = rnd_ff;
      idx_in    = idx_ff;
      blk_in    = blk_ff;
      wk_in     = wk_ff;
      cv_in     = cv_ff;
      item_pop  = 1'b0;
      start_cmp = 1'b0;
      cmp_ret   = ST_IDLE;
      wr_en     = 1'b0;
      wr_byte   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               if (item_data.byte_present) begin
                  wr_en   = 1'b1;
                  wr_byte = item_data.data_byte;
                  len_in  = len_ff + 61'd1;
                  fill_in = fill_ff + 6'd1;
                  if (fill_ff == LAST_POS) begin
                     start_cmp = 1'b1;
                     cmp_ret   = item_data.message_end ? ST_PAD80 : ST_IDLE;
                  end else if (item_data.message_end) begin
                     state_in = ST_PAD80;
                  end
               end else if (item_data.message_end) begin
                  state_in = ST_PAD80;
               end
            end
         end
         ST_PAD80: begin
            wr_en   = 1'b1;
            wr_byte = PAD_BYTE;
            fill_in = fill_ff + 6'd1;
            if (fill_ff == LAST_POS) begin
               start_cmp = 1'b1;
               cmp_ret   = ST_PADZ;
            end else begin
               state_in = ST_PADZ;
            end
         end
         ST_PADZ: begin
            if (fill_ff == LEN_POS) begin
               blk_in[14] = bits[63:32];
               blk_in[15] = bits[31:0];
               fill_in    = '0;
               start_cmp  = 1'b1;
               cmp_ret    = ST_EMIT;
            end else begin
               wr_en   = 1'b1;
               fill_in = fill_ff + 6'd1;
               if (fill_ff == LAST_POS) begin
                  start_cmp = 1'b1;
                  cmp_ret   = ST_PADZ;
               end
            end
         end
         ST_ROUND: begin
            for (int i = 0; i < 15; i++) begin
               blk_in[i] = blk_ff[i+1];
            end
            blk_in[15] = w_new;
            wk_in[7] = wk_ff[6];
            wk_in[6] = wk_ff[5];
            wk_in[5] = wk_ff[4];
            wk_in[4] = wk_ff[3] + t1;
            wk_in[3] = wk_ff[2];
            wk_in[2] = wk_ff[1];
            wk_in[1] = wk_ff[0];
            wk_in[0] = t1 + t2;
            rnd_in   = rnd_ff + 6'd1;
            if (rnd_ff == LAST_POS) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               cv_in[i] = cv_ff[i] + wk_ff[i];
            end
            state_in = ret_ff;
         end
         ST_EMIT: begin
            if (rsp_pop) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cv_in    = IV;
                  fill_in  = '0;
                  len_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (wr_en) begin
         blk_in[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] = wr_byte;
      end
      if (start_cmp) begin
         wk_in    = cv_ff;
         rnd_in   = '0;
         ret_in   = cmp_ret;
         state_in = ST_ROUND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         fill_ff  <= '0;
         len_ff   <= '0;
         rnd_ff   <= '0;
         idx_ff   <= '0;
         cv_ff    <= IV;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fill_ff  <= fill_in;
         len_ff   <= len_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
         cv_ff    <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      wk_ff  <= wk_in;
   end

endmodule

// ===== rtl/sha_checker.sv =====
module sha_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_full,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input sha_pkg::rsp_word_type rsp_data
);
   import sha_pkg::*;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.digest_last == (rsp_data.word_index == 3'd7)))
      else $error("digest_last out of step with word_index");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.digest_last) |=>
         (!rsp_empty && rsp_data.word_index == $past(rsp_data.word_index) + 3'd1))
      else $error("digest words not consecutive");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled digest word changed");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
